// File: rtl/tpct_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpct_pkg
// Shared types, codes and helpers of the transmit power calibration table.
// ---------------------------------------------------------------------------
package tpct_pkg;

   localparam int DEF_NUM_CHANNELS        = 16;
   localparam int DEF_FIRST_CHANNEL       = 11;
   localparam int DEF_ENTRIES_PER_CHANNEL = 8;
   localparam int DEF_MAX_SETTING_BYTES   = 8;

   localparam int POWER_W   = 16;
   localparam int SETTING_W = 64;
   localparam int LEN_W     = 4;

   localparam logic signed [POWER_W-1:0] NO_TARGET = 16'sh7FFF;

   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_SET_TARGET = 2'd2,
      CMD_GET        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_NOSPACE  = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FETCH,
      S_FETCH_WAIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] power;
      logic [SETTING_W-1:0]      setting;
      logic [LEN_W-1:0]          length;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic step;
   } srch_ctrl_type;

   function automatic logic [SETTING_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [SETTING_W-1:0] m;
      m = '0;
      for (int b = 0; b < SETTING_W / 8; b++) begin
         m[b*8 +: 8] = (LEN_W'(b) < len) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

// File: rtl/tx_power_calibration_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tx_power_calibration_table_top
// Per-channel transmit power calibration store with target lookup.
// ---------------------------------------------------------------------------
// One transaction at a time. Clear all, set target and commands rejected at
// decode pass from decode straight to the result. Add and a get that searches
// scan the channel's n stored entries, n being its entry count: a shared compare
// unit looks at one stored entry per cycle through the single read port of the
// entry memory. A get on the cached channel skips the search. The next request
// is taken in the cycle after the result is loaded. The result sits in an output
// register; the next request is taken while it waits, but cannot finish until
// it has gone.
module tx_power_calibration_table_top #(
   parameter int NUM_CHANNELS        = tpct_pkg::DEF_NUM_CHANNELS,
   parameter int FIRST_CHANNEL       = tpct_pkg::DEF_FIRST_CHANNEL,
   parameter int ENTRIES_PER_CHANNEL = tpct_pkg::DEF_ENTRIES_PER_CHANNEL,
   parameter int MAX_SETTING_BYTES   = tpct_pkg::DEF_MAX_SETTING_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_command,
   input  logic [7:0]                           req_channel,
   input  logic signed [tpct_pkg::POWER_W-1:0]  req_power,
   input  logic [tpct_pkg::SETTING_W-1:0]       req_raw_setting,
   input  logic [7:0]                           req_setting_length,
   input  logic [15:0]                          req_buffer_capacity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic signed [tpct_pkg::POWER_W-1:0]  rsp_target_power,
   output logic signed [tpct_pkg::POWER_W-1:0]  rsp_actual_power,
   output logic [tpct_pkg::SETTING_W-1:0]       rsp_raw_setting_res,
   output logic [tpct_pkg::LEN_W-1:0]           rsp_setting_length_res
);
   import tpct_pkg::*;

   localparam int CI_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int EI_W   = (ENTRIES_PER_CHANNEL > 1) ? $clog2(ENTRIES_PER_CHANNEL) : 1;
   localparam int CNT_W  = $clog2(ENTRIES_PER_CHANNEL + 1);
   localparam int ADDR_W = CI_W + EI_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES_PER_CHANNEL);

   state_type                 state_ff, state_in;

   cmd_type                   cmd_ff, cmd_in;
   logic [7:0]                ch_ff, ch_in;
   logic signed [POWER_W-1:0] pw_ff, pw_in;
   logic [SETTING_W-1:0]      set_ff, set_in;
   logic [7:0]                slen_ff, slen_in;
   logic [15:0]               cap_ff, cap_in;

   logic signed [POWER_W-1:0] tgt_tab_ff [NUM_CHANNELS];
   logic signed [POWER_W-1:0] tgt_tab_in [NUM_CHANNELS];
   logic [CNT_W-1:0]          cnt_ff [NUM_CHANNELS];
   logic [CNT_W-1:0]          cnt_in [NUM_CHANNELS];

   logic [7:0]                last_ch_ff, last_ch_in;
   logic [EI_W-1:0]           cached_idx_ff, cached_idx_in;
   logic                      cache_valid_ff, cache_valid_in;

   logic signed [POWER_W-1:0] key_ff, key_in;
   logic signed [POWER_W-1:0] tgt_ff, tgt_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                      cmp_valid_ff, cmp_valid_in;
   logic [EI_W-1:0]           cmp_idx_ff, cmp_idx_in;
   logic [EI_W-1:0]           idx_ff, idx_in;

   status_type                res_status_ff, res_status_in;
   logic signed [POWER_W-1:0] res_tgt_ff, res_tgt_in;
   logic signed [POWER_W-1:0] res_act_ff, res_act_in;
   logic [SETTING_W-1:0]      res_set_ff, res_set_in;
   logic [LEN_W-1:0]          res_len_ff, res_len_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic signed [POWER_W-1:0] rsp_tgt_ff, rsp_tgt_in;
   logic signed [POWER_W-1:0] rsp_act_ff, rsp_act_in;
   logic [SETTING_W-1:0]      rsp_set_ff, rsp_set_in;
   logic [LEN_W-1:0]          rsp_len_ff, rsp_len_in;

   logic [7:0]                ch_off;
   logic [CI_W-1:0]           ci;
   logic                      chan_ok;
   logic                      scan_rd_en;

   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr;
   entry_type                 ram_wdata;
   logic                      ram_re;
   logic [ADDR_W-1:0]         ram_raddr;
   entry_type                 ram_rdata;

   srch_ctrl_type             srch_ctrl;
   logic [EI_W-1:0]           srch_idx;
   logic                      srch_dup;

   tpct_entry_ram #(
      .ADDR_W (ADDR_W)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tpct_search_unit #(
      .IDX_W (EI_W)
   ) u_search_unit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (srch_ctrl),
      .key       (key_ff),
      .power     (ram_rdata.power),
      .index     (cmp_idx_ff),
      .sel_index (srch_idx),
      .dup       (srch_dup)
   );

   assign ch_off  = ch_ff - 8'(FIRST_CHANNEL);
   assign ci      = ch_off[CI_W-1:0];
   assign chan_ok = (ch_ff >= 8'(FIRST_CHANNEL)) &&
                    ({1'b0, ch_ff} < 9'(FIRST_CHANNEL + NUM_CHANNELS));
   assign scan_rd_en = (scan_idx_ff != n_ff);

   assign ram_waddr         = {ci, n_ff[EI_W-1:0]};
   assign ram_wdata.power   = pw_ff;
   assign ram_wdata.setting = set_ff & byte_mask(slen_ff[LEN_W-1:0]);
   assign ram_wdata.length  = slen_ff[LEN_W-1:0];

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      ch_in          = ch_ff;
      pw_in          = pw_ff;
      set_in         = set_ff;
      slen_in        = slen_ff;
      cap_in         = cap_ff;
      tgt_tab_in     = tgt_tab_ff;
      cnt_in         = cnt_ff;
      last_ch_in     = last_ch_ff;
      cached_idx_in  = cached_idx_ff;
      cache_valid_in = cache_valid_ff;
      key_in         = key_ff;
      tgt_in         = tgt_ff;
      n_in           = n_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_valid_in   = cmp_valid_ff;
      cmp_idx_in     = cmp_idx_ff;
      idx_in         = idx_ff;
      res_status_in  = res_status_ff;
      res_tgt_in     = res_tgt_ff;
      res_act_in     = res_act_ff;
      res_set_in     = res_set_ff;
      res_len_in     = res_len_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_tgt_in     = rsp_tgt_ff;
      rsp_act_in     = rsp_act_ff;
      rsp_set_in     = rsp_set_ff;
      rsp_len_in     = rsp_len_ff;
      req_ready      = 1'b0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_raddr      = {ci, scan_idx_ff[EI_W-1:0]};
      srch_ctrl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_command);
               ch_in    = req_channel;
               pw_in    = req_power;
               set_in   = req_raw_setting;
               slen_in  = req_setting_length;
               cap_in   = req_buffer_capacity;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = ST_OK;
            res_tgt_in    = '0;
            res_act_in    = '0;
            res_set_in    = '0;
            res_len_in    = '0;
            state_in      = S_DONE;
            if (cmd_ff == CMD_CLEAR) begin
               for (int k = 0; k < NUM_CHANNELS; k++) begin
                  cnt_in[k] = '0;
               end
               cache_valid_in = 1'b0;
            end else if (!chan_ok) begin
               res_status_in = ST_INVALID;
            end else begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (slen_ff > 8'(MAX_SETTING_BYTES)) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        key_in          = pw_ff;
                        n_in            = cnt_ff[ci];
                        scan_idx_in     = '0;
                        cmp_valid_in    = 1'b0;
                        srch_ctrl.clear = 1'b1;
                        state_in        = S_SCAN;
                     end
                  end
                  CMD_SET_TARGET: begin
                     tgt_tab_in[ci] = pw_ff;
                     if (ch_ff == last_ch_ff) begin
                        cache_valid_in = 1'b0;
                     end
                  end
                  CMD_GET: begin
                     tgt_in = tgt_tab_ff[ci];
                     if (cache_valid_ff && (ch_ff == last_ch_ff)) begin
                        idx_in   = cached_idx_ff;
                        state_in = S_FETCH;
                     end else if ((tgt_tab_ff[ci] == NO_TARGET) || (cnt_ff[ci] == '0)) begin
                        res_status_in = ST_NOTFOUND;
                     end else begin
                        key_in          = tgt_tab_ff[ci];
                        n_in            = cnt_ff[ci];
                        scan_idx_in     = '0;
                        cmp_valid_in    = 1'b0;
                        srch_ctrl.clear = 1'b1;
                        state_in        = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SCAN: begin
            ram_re         = scan_rd_en;
            scan_idx_in    = scan_rd_en ? (scan_idx_ff + 1'b1) : scan_idx_ff;
            cmp_valid_in   = scan_rd_en;
            cmp_idx_in     = scan_idx_ff[EI_W-1:0];
            srch_ctrl.step = cmp_valid_ff;
            if (!scan_rd_en && !cmp_valid_ff) begin
               if (cmd_ff == CMD_ADD) begin
                  state_in = S_DONE;
                  if (srch_dup) begin
                     res_status_in = ST_INVALID;
                  end else if (n_ff >= CNT_FULL) begin
                     res_status_in = ST_NOSPACE;
                  end else begin
                     ram_we     = 1'b1;
                     cnt_in[ci] = n_ff + 1'b1;
                     if (ch_ff == last_ch_ff) begin
                        cache_valid_in = 1'b0;
                     end
                  end
               end else begin
                  idx_in         = srch_idx;
                  cached_idx_in  = srch_idx;
                  last_ch_in     = ch_ff;
                  cache_valid_in = 1'b1;
                  state_in       = S_FETCH;
               end
            end
         end

         S_FETCH: begin
            ram_re    = 1'b1;
            ram_raddr = {ci, idx_ff};
            state_in  = S_FETCH_WAIT;
         end

         S_FETCH_WAIT: begin
            res_tgt_in = tgt_ff;
            res_act_in = ram_rdata.power;
            if (cap_ff < 16'(ram_rdata.length)) begin
               res_status_in = ST_INVALID;
               res_set_in    = '0;
               res_len_in    = '0;
            end else begin
               res_status_in = ST_OK;
               res_set_in    = ram_rdata.setting;
               res_len_in    = ram_rdata.length;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tgt_in    = res_tgt_ff;
               rsp_act_in    = res_act_ff;
               rsp_set_in    = res_set_ff;
               rsp_len_in    = res_len_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            tgt_tab_ff[k] <= NO_TARGET;
            cnt_ff[k]     <= '0;
         end
         last_ch_ff     <= '0;
         cached_idx_ff  <= '0;
         cache_valid_ff <= 1'b0;
         cmp_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tgt_tab_ff     <= tgt_tab_in;
         cnt_ff         <= cnt_in;
         last_ch_ff     <= last_ch_in;
         cached_idx_ff  <= cached_idx_in;
         cache_valid_ff <= cache_valid_in;
         cmp_valid_ff   <= cmp_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ch_ff         <= ch_in;
      pw_ff         <= pw_in;
      set_ff        <= set_in;
      slen_ff       <= slen_in;
      cap_ff        <= cap_in;
      key_ff        <= key_in;
      tgt_ff        <= tgt_in;
      n_ff          <= n_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_tgt_ff    <= res_tgt_in;
      res_act_ff    <= res_act_in;
      res_set_ff    <= res_set_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tgt_ff    <= rsp_tgt_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_set_ff    <= rsp_set_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_target_power       = rsp_tgt_ff;
   assign rsp_actual_power       = rsp_act_ff;
   assign rsp_raw_setting_res    = rsp_set_ff;
   assign rsp_setting_length_res = rsp_len_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transaction is in progress");

   a_write_below_capacity: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (n_ff < CNT_FULL))
      else $error("entry written into a full channel");

   a_clear_drops_cache: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE && cmd_ff == CMD_CLEAR) |=> !cache_valid_ff)
      else $error("cache still valid after clear all");

   a_search_fills_cache: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && cmd_ff == CMD_GET && !scan_rd_en && !cmp_valid_ff)
      |=> (cache_valid_ff && state_ff == S_FETCH))
      else $error("completed search did not fill the cache");

   a_ok_length_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |-> (rsp_setting_length_res <= LEN_W'(MAX_SETTING_BYTES)))
      else $error("returned setting length above maximum");
`endif

endmodule

// File: rtl/tpct_entry_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpct_entry_ram
// Calibration entry store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tpct_entry_ram #(
   parameter int ADDR_W = 7
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_W-1:0]    waddr,
   input  tpct_pkg::entry_type  wdata,
   input  logic                 re,
   input  logic [ADDR_W-1:0]    raddr,
   output tpct_pkg::entry_type  rdata
);
   import tpct_pkg::*;

   entry_type mem_ff [2**ADDR_W];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/tpct_search_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tpct_search_unit
// Shared compare unit: one stored power per step, tracks best at-or-below key,
// lowest power above key and key match.
// ---------------------------------------------------------------------------
module tpct_search_unit #(
   parameter int IDX_W = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tpct_pkg::srch_ctrl_type               ctrl,
   input  logic signed [tpct_pkg::POWER_W-1:0]   key,
   input  logic signed [tpct_pkg::POWER_W-1:0]   power,
   input  logic [IDX_W-1:0]                      index,
   output logic [IDX_W-1:0]                      sel_index,
   output logic                                  dup
);
   import tpct_pkg::*;

   logic                      fv_ff, fv_in;
   logic                      mv_ff, mv_in;
   logic                      dup_ff, dup_in;
   logic signed [POWER_W-1:0] fp_ff, fp_in;
   logic signed [POWER_W-1:0] mp_ff, mp_in;
   logic [IDX_W-1:0]          fi_ff, fi_in;
   logic [IDX_W-1:0]          mi_ff, mi_in;
   logic                      take_max;
   logic                      take_min;

   always_comb begin
      take_max = (power <= key) && (!fv_ff || (fp_ff <= power));
      take_min = !take_max && (!mv_ff || (power < mp_ff));
      fv_in  = fv_ff;
      mv_in  = mv_ff;
      dup_in = dup_ff;
      fp_in  = fp_ff;
      mp_in  = mp_ff;
      fi_in  = fi_ff;
      mi_in  = mi_ff;
      if (ctrl.clear) begin
         fv_in  = 1'b0;
         mv_in  = 1'b0;
         dup_in = 1'b0;
      end else if (ctrl.step) begin
         if (power == key) begin
            dup_in = 1'b1;
         end
         if (take_max) begin
            fv_in = 1'b1;
            fp_in = power;
            fi_in = index;
         end else if (take_min) begin
            mv_in = 1'b1;
            mp_in = power;
            mi_in = index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff  <= 1'b0;
         mv_ff  <= 1'b0;
         dup_ff <= 1'b0;
      end else begin
         fv_ff  <= fv_in;
         mv_ff  <= mv_in;
         dup_ff <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      fp_ff <= fp_in;
      mp_ff <= mp_in;
      fi_ff <= fi_in;
      mi_ff <= mi_in;
   end

   assign sel_index = fv_ff ? fi_ff : mi_ff;
   assign dup       = dup_ff;

endmodule
